FILE: rtl/kcl_pkg.sv
// Shared types, constants and key map of the keypad combination lock.
package kcl_pkg;

  localparam int unsigned CODE_DIGITS = 4;
  localparam int unsigned PTR_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int unsigned DISP_POS    = 4;
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned TRY_W       = 3;
  localparam int unsigned KEY_W       = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_W       = 12;

  typedef logic [KEY_W-1:0] disp_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRELOCK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKDOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS = 3'd4;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 12'd200;
  localparam logic [CNT_W-1:0] OPEN_RST     = 12'd20;
  localparam logic [CNT_W-1:0] PRELOCK_RST  = 12'd2000;
  localparam logic [CNT_W-1:0] LOCKDOWN_RST = 12'd1000;
  localparam logic [TRY_W-1:0] ATTEMPTS_RST = 3'd5;
  localparam logic [TRY_W-1:0] TRIES_MAX    = 3'd7;

  localparam disp_t KEY_A     = 5'd10;
  localparam disp_t KEY_B     = 5'd11;
  localparam disp_t KEY_NONE  = 5'd16;
  localparam disp_t DIG_LIMIT = 5'd10;
  localparam disp_t BLANK     = 5'd16;
  localparam disp_t SAVED_RST = 5'd0;

  localparam disp_t PAT_IDLE [DISP_POS] = '{5'd0, 5'd0, 5'd0, 5'd0};
  localparam disp_t PAT_OPEN [DISP_POS] = '{5'd0, 5'd17, 5'd14, 5'd18};
  localparam disp_t PAT_LOCK [DISP_POS] = '{5'd16, 5'd15, 5'd0, 5'd12};
  localparam disp_t PAT_DOWN [DISP_POS] = '{5'd19, 5'd15, 5'd13, 5'd19};

  typedef enum logic [2:0] {
    LP_IDLE     = 3'd0,
    LP_OPEN     = 3'd1,
    LP_CHOOSE   = 3'd2,
    LP_PRELOCK  = 3'd3,
    LP_LOCKED   = 3'd4,
    LP_LOCKDOWN = 3'd5
  } lock_phase_e;

  typedef enum logic [1:0] {
    DB_IDLE    = 2'd0,
    DB_PRESS   = 2'd1,
    DB_PROCESS = 2'd2,
    DB_RELEASE = 2'd3
  } deb_phase_e;

  typedef enum logic [2:0] {
    SH_IDLE  = 3'd0,
    SH_OPEN  = 3'd1,
    SH_ENTRY = 3'd2,
    SH_LOCK  = 3'd3,
    SH_DOWN  = 3'd4
  } show_sel_e;

  // Keypad position (row*4+col) to key value.
  function automatic disp_t key_map(input logic [3:0] pos);
    disp_t k;
    case (pos)
      4'd0:    k = 5'd10;
      4'd1:    k = 5'd3;
      4'd2:    k = 5'd2;
      4'd3:    k = 5'd1;
      4'd4:    k = 5'd11;
      4'd5:    k = 5'd6;
      4'd6:    k = 5'd5;
      4'd7:    k = 5'd4;
      4'd8:    k = 5'd12;
      4'd9:    k = 5'd9;
      4'd10:   k = 5'd8;
      4'd11:   k = 5'd7;
      4'd12:   k = 5'd13;
      4'd13:   k = 5'd15;
      4'd14:   k = 5'd0;
      4'd15:   k = 5'd14;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/kcl_if.sv
// Valid/ready channel interfaces for keypad scan items and lock status results.
interface kcl_in_if
  import kcl_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       key_down;
  logic [1:0] key_row;
  logic [1:0] key_col;

  modport source (output valid, output key_down, output key_row, output key_col,
                  input ready);
  modport sink   (input valid, input key_down, input key_row, input key_col,
                  output ready);
endinterface

interface kcl_out_if
  import kcl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             latch_drive;
  logic [2:0]       mode;
  disp_t            digit_zero;
  disp_t            digit_one;
  disp_t            digit_two;
  disp_t            digit_three;
  logic [TRY_W-1:0] tries;

  modport source (output valid, output latch_drive, output mode, output digit_zero,
                  output digit_one, output digit_two, output digit_three,
                  output tries, input ready);
  modport sink   (input valid, input latch_drive, input mode, input digit_zero,
                  input digit_one, input digit_two, input digit_three,
                  input tries, output ready);
endinterface

FILE: rtl/keypad_combination_lock.sv
// Keypad combination lock: debounce, code entry, lock phases and status output.
// One scan tick enters per transaction and yields exactly one status transaction.
// The whole update (debounce step, key action, phase change and display select)
// is one level of next-state logic into the state registers and a single output
// register, so a tick is taken every cycle and its status appears in the next
// cycle; the input stalls only while the output register holds a status that the
// sink has not taken. Configuration writes take effect at the next clock edge.
module keypad_combination_lock
  import kcl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  kcl_in_if.sink               in_i,
  kcl_out_if.source            out_o
);

  // configuration registers
  logic [CNT_W-1:0] deb_ticks_q, open_ticks_q, pre_ticks_q, down_ticks_q;
  logic [TRY_W-1:0] max_att_q;

  // state registers
  deb_phase_e       deb_q, deb_d;
  logic [CNT_W-1:0] deb_cnt_q, deb_cnt_d;
  logic [3:0]       held_q, held_d;
  disp_t            entry_q [CODE_DIGITS];
  disp_t            entry_d [CODE_DIGITS];
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             full_q, full_d;
  disp_t            saved_q [CODE_DIGITS];
  disp_t            saved_d [CODE_DIGITS];
  lock_phase_e      lock_q, lock_d;
  logic [CNT_W-1:0] ph_cnt_q, ph_cnt_d;
  logic [TRY_W-1:0] tries_q, tries_d;
  show_sel_e        show_q, show_d;

  // output register
  logic             out_valid_q;
  logic             latch_q;
  logic [2:0]       mode_q;
  disp_t            disp_q [DISP_POS];
  disp_t            disp_d [DISP_POS];

  logic             in_fire;
  logic             scan_en;
  disp_t            key;
  logic             key_dig;
  logic             match;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= DEBOUNCE_RST;
      open_ticks_q <= OPEN_RST;
      pre_ticks_q  <= PRELOCK_RST;
      down_ticks_q <= LOCKDOWN_RST;
      max_att_q    <= ATTEMPTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: deb_ticks_q  <= cfg_data_i;
        CFG_OPEN:     open_ticks_q <= cfg_data_i;
        CFG_PRELOCK:  pre_ticks_q  <= cfg_data_i;
        CFG_LOCKDOWN: down_ticks_q <= cfg_data_i;
        CFG_ATTEMPTS: max_att_q    <= cfg_data_i[TRY_W-1:0];
        default: ;
      endcase
    end
  end

  // next state of one scan tick
  always_comb begin
    deb_d    = deb_q;
    deb_cnt_d = deb_cnt_q;
    held_d   = held_q;
    entry_d  = entry_q;
    ptr_d    = ptr_q;
    full_d   = full_q;
    saved_d  = saved_q;
    lock_d   = lock_q;
    ph_cnt_d = ph_cnt_q;
    tries_d  = tries_q;
    show_d   = show_q;
    key      = KEY_NONE;
    match    = 1'b1;

    scan_en = (lock_q == LP_IDLE) || (lock_q == LP_CHOOSE) ||
              (lock_q == LP_PRELOCK) || (lock_q == LP_LOCKED);

    if (lock_q == LP_IDLE) begin
      full_d = 1'b0;
    end

    if (scan_en) begin
      case (deb_q)
        DB_IDLE: begin
          if (in_i.key_down) begin
            held_d    = {in_i.key_row, in_i.key_col};
            deb_d     = DB_PRESS;
            deb_cnt_d = '0;
          end
        end
        DB_PRESS: begin
          if (in_i.key_down) held_d = {in_i.key_row, in_i.key_col};
          if (deb_cnt_q >= deb_ticks_q) deb_d = DB_PROCESS;
          else deb_cnt_d = deb_cnt_q + 1'b1;
        end
        DB_PROCESS: begin
          key = key_map(held_q);
          if (key < DIG_LIMIT) begin
            entry_d[ptr_q] = key;
            if (ptr_q == PTR_W'(CODE_DIGITS - 1)) begin
              ptr_d  = '0;
              full_d = 1'b1;
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end
          deb_d     = DB_RELEASE;
          deb_cnt_d = '0;
        end
        default: begin
          if (deb_cnt_q >= deb_ticks_q) deb_d = DB_IDLE;
          else deb_cnt_d = deb_cnt_q + 1'b1;
        end
      endcase
    end

    key_dig = key < DIG_LIMIT;

    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_d[i] != saved_q[i]) match = 1'b0;
    end

    case (lock_q)
      LP_IDLE: begin
        show_d = SH_IDLE;
        if (key == KEY_A) begin
          lock_d   = LP_OPEN;
          ph_cnt_d = '0;
        end else if (key_dig) begin
          lock_d = LP_CHOOSE;
        end
      end
      LP_OPEN: begin
        show_d = SH_OPEN;
        if (ph_cnt_q >= open_ticks_q) lock_d = LP_IDLE;
        else ph_cnt_d = ph_cnt_q + 1'b1;
      end
      LP_CHOOSE: begin
        show_d = SH_ENTRY;
        if (key == KEY_B && full_d) begin
          lock_d   = LP_PRELOCK;
          full_d   = 1'b0;
          ph_cnt_d = '0;
        end
      end
      LP_PRELOCK: begin
        if (key_dig) begin
          lock_d = LP_IDLE;
        end else if (ph_cnt_q >= pre_ticks_q) begin
          // arm: move the entry into the saved code and blank the entry
          for (int i = 0; i < CODE_DIGITS; i++) begin
            saved_d[i] = entry_d[i];
            entry_d[i] = BLANK;
          end
          ptr_d   = '0;
          full_d  = 1'b0;
          lock_d  = LP_LOCKED;
          show_d  = SH_LOCK;
          tries_d = '0;
        end else begin
          ph_cnt_d = ph_cnt_q + 1'b1;
        end
      end
      LP_LOCKED: begin
        if (key_dig) show_d = SH_ENTRY;
        if (key == KEY_A && full_d) begin
          if (match) begin
            lock_d   = LP_OPEN;
            ph_cnt_d = '0;
            for (int i = 0; i < CODE_DIGITS; i++) saved_d[i] = BLANK;
            show_d   = SH_OPEN;
            tries_d  = '0;
          end else begin
            tries_d = (tries_q < TRIES_MAX) ? tries_q + 1'b1 : tries_q;
            show_d  = SH_LOCK;
            if (tries_d >= max_att_q) begin
              lock_d   = LP_LOCKDOWN;
              ph_cnt_d = '0;
              show_d   = SH_DOWN;
              tries_d  = '0;
            end
          end
          for (int i = 0; i < CODE_DIGITS; i++) entry_d[i] = BLANK;
          ptr_d  = '0;
          full_d = 1'b0;
        end
      end
      default: begin
        show_d = SH_DOWN;
        if (ph_cnt_q >= down_ticks_q) begin
          lock_d = LP_LOCKED;
          show_d = SH_LOCK;
        end else begin
          ph_cnt_d = ph_cnt_q + 1'b1;
        end
      end
    endcase
  end

  // display codes of the next status
  for (genvar g = 0; g < DISP_POS; g++) begin : g_disp
    disp_t ent;
    if (g < CODE_DIGITS) begin : g_ent
      assign ent = entry_d[g];
    end else begin : g_blank
      assign ent = BLANK;
    end
    always_comb begin
      case (show_d)
        SH_IDLE:  disp_d[g] = PAT_IDLE[g];
        SH_OPEN:  disp_d[g] = PAT_OPEN[g];
        SH_ENTRY: disp_d[g] = ent;
        SH_LOCK:  disp_d[g] = PAT_LOCK[g];
        SH_DOWN:  disp_d[g] = PAT_DOWN[g];
        default:  disp_d[g] = BLANK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= DB_IDLE;
      deb_cnt_q <= '0;
      held_q    <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        entry_q[i] <= BLANK;
        saved_q[i] <= SAVED_RST;
      end
      ptr_q    <= '0;
      full_q   <= 1'b0;
      lock_q   <= LP_IDLE;
      ph_cnt_q <= '0;
      tries_q  <= '0;
      show_q   <= SH_IDLE;
    end else if (in_fire) begin
      deb_q     <= deb_d;
      deb_cnt_q <= deb_cnt_d;
      held_q    <= held_d;
      entry_q   <= entry_d;
      ptr_q     <= ptr_d;
      full_q    <= full_d;
      saved_q   <= saved_d;
      lock_q    <= lock_d;
      ph_cnt_q  <= ph_cnt_d;
      tries_q   <= tries_d;
      show_q    <= show_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      latch_q <= !(lock_d == LP_OPEN || lock_d == LP_PRELOCK);
      mode_q  <= lock_d;
      disp_q  <= disp_d;
    end
  end

  logic [TRY_W-1:0] tries_out_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) tries_out_q <= tries_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.latch_drive = latch_q;
  assign out_o.mode        = mode_q;
  assign out_o.digit_zero  = disp_q[0];
  assign out_o.digit_one   = disp_q[1];
  assign out_o.digit_two   = disp_q[2];
  assign out_o.digit_three = disp_q[3];
  assign out_o.tries       = tries_out_q;

  // timed phases start from a cleared counter
  a_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lock_q == LP_OPEN && $past(lock_q) != LP_OPEN) ||
     (lock_q == LP_PRELOCK && $past(lock_q) != LP_PRELOCK) ||
     (lock_q == LP_LOCKDOWN && $past(lock_q) != LP_LOCKDOWN)) |-> ph_cnt_q == '0)
    else $error("phase counter not cleared on entry to a timed phase");

  // wrong tries only survive while the lock is armed
  a_tries_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tries_q != '0 |-> lock_q == LP_LOCKED)
    else $error("wrong tries held outside the locked phase");

  // debounce is frozen while open or in lockdown
  a_deb_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_q == LP_OPEN || lock_q == LP_LOCKDOWN) |=>
      (deb_q == $past(deb_q) && deb_cnt_q == $past(deb_cnt_q)))
    else $error("debounce advanced while open or in lockdown");

endmodule

FILE: verif/tb_top.sv
// Testbench of the keypad combination lock: reactive keystroke stimulus checked against a mirrored lock.
module tb_top;
  import kcl_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned STROKE_GUARD = 20000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned HOLD_CYCLES  = 64;

  localparam disp_t            DIGIT_TOP   = 5'd10;
  localparam disp_t            OPEN_KEY    = 5'd10;
  localparam disp_t            CONFIRM_KEY = 5'd11;
  localparam disp_t            NO_KEY_CODE = 5'd16;
  localparam disp_t            BLANK_CODE  = 5'd16;
  localparam logic [TRY_W-1:0] TRIES_CAP   = 3'd7;

  localparam disp_t KEYPAD_MAP [16] = '{5'd10, 5'd3, 5'd2, 5'd1, 5'd11, 5'd6, 5'd5, 5'd4,
                                        5'd12, 5'd9, 5'd8, 5'd7, 5'd13, 5'd15, 5'd0, 5'd14};
  localparam disp_t SHOW_OPEN [4] = '{5'd0, 5'd17, 5'd14, 5'd18};
  localparam disp_t SHOW_LOCK [4] = '{5'd16, 5'd15, 5'd0, 5'd12};
  localparam disp_t SHOW_DOWN [4] = '{5'd19, 5'd15, 5'd13, 5'd19};

  typedef struct packed {
    logic             latch_drive;
    logic [2:0]       mode;
    disp_t            digit_zero;
    disp_t            digit_one;
    disp_t            digit_two;
    disp_t            digit_three;
    logic [TRY_W-1:0] tries;
  } lock_status_t;

  class lock_mirror;
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] open_ticks;
    logic [CNT_W-1:0] prelock_ticks;
    logic [CNT_W-1:0] lockdown_ticks;
    logic [TRY_W-1:0] max_attempts;
    deb_phase_e       deb_ph;
    logic [CNT_W-1:0] deb_cnt;
    logic [3:0]       held_pos;
    disp_t            entry [CODE_DIGITS];
    int unsigned      entry_ptr;
    bit               entry_full;
    disp_t            saved [CODE_DIGITS];
    lock_phase_e      lock_ph;
    logic [CNT_W-1:0] ph_cnt;
    logic [TRY_W-1:0] wrong_tries;
    show_sel_e        shown;
    lock_status_t     due_status [$];
    int unsigned      n_err;

    function new();
      debounce_ticks = 12'd200;
      open_ticks     = 12'd20;
      prelock_ticks  = 12'd2000;
      lockdown_ticks = 12'd1000;
      max_attempts   = 3'd5;
      deb_ph         = DB_IDLE;
      deb_cnt        = '0;
      held_pos       = '0;
      foreach (entry[i]) begin
        entry[i] = BLANK_CODE;
        saved[i] = '0;
      end
      entry_ptr   = 0;
      entry_full  = 1'b0;
      lock_ph     = LP_IDLE;
      ph_cnt      = '0;
      wrong_tries = '0;
      shown       = SH_IDLE;
      n_err       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_DEBOUNCE: debounce_ticks = data;
        CFG_OPEN:     open_ticks = data;
        CFG_PRELOCK:  prelock_ticks = data;
        CFG_LOCKDOWN: lockdown_ticks = data;
        CFG_ATTEMPTS: max_attempts = data[TRY_W-1:0];
        default: ;
      endcase
    endfunction

    function void blank_entry();
      foreach (entry[i]) entry[i] = BLANK_CODE;
      entry_ptr = 0;
    endfunction

    // Advance the debounce machine; a key value comes out only in the process step.
    function disp_t scan(bit down, logic [3:0] pos);
      disp_t key;
      key = NO_KEY_CODE;
      case (deb_ph)
        DB_IDLE: begin
          if (down) begin
            held_pos = pos;
            deb_ph   = DB_PRESS;
            deb_cnt  = '0;
          end
        end
        DB_PRESS: begin
          if (down) held_pos = pos;
          if (deb_cnt >= debounce_ticks) deb_ph = DB_PROCESS;
          else deb_cnt++;
        end
        DB_PROCESS: begin
          key = KEYPAD_MAP[held_pos];
          if (key < DIGIT_TOP) begin
            entry[entry_ptr] = key;
            entry_ptr++;
            if (entry_ptr >= CODE_DIGITS) begin
              entry_full = 1'b1;
              entry_ptr  = 0;
            end
          end
          deb_ph  = DB_RELEASE;
          deb_cnt = '0;
        end
        default: begin
          if (deb_cnt >= debounce_ticks) deb_ph = DB_IDLE;
          else deb_cnt++;
        end
      endcase
      return key;
    endfunction

    function void take_tick(bit down, logic [1:0] row, logic [1:0] col);
      disp_t        key;
      bit           match;
      disp_t        show [4];
      lock_status_t st;
      case (lock_ph)
        LP_IDLE: begin
          shown      = SH_IDLE;
          entry_full = 1'b0;
          key        = scan(down, {row, col});
          if (key == OPEN_KEY) begin
            lock_ph = LP_OPEN;
            ph_cnt  = '0;
          end else if (key < DIGIT_TOP) begin
            lock_ph = LP_CHOOSE;
          end
        end
        LP_OPEN: begin
          shown = SH_OPEN;
          if (ph_cnt >= open_ticks) lock_ph = LP_IDLE;
          else ph_cnt++;
        end
        LP_CHOOSE: begin
          shown = SH_ENTRY;
          key   = scan(down, {row, col});
          if (key == CONFIRM_KEY && entry_full) begin
            lock_ph    = LP_PRELOCK;
            entry_full = 1'b0;
            ph_cnt     = '0;
          end
        end
        LP_PRELOCK: begin
          key = scan(down, {row, col});
          // A digit cancels, even on the tick that would arm.
          if (key < DIGIT_TOP) begin
            lock_ph = LP_IDLE;
          end else if (ph_cnt >= prelock_ticks) begin
            foreach (saved[i]) saved[i] = entry[i];
            blank_entry();
            entry_full  = 1'b0;
            lock_ph     = LP_LOCKED;
            shown       = SH_LOCK;
            wrong_tries = '0;
          end else begin
            ph_cnt++;
          end
        end
        LP_LOCKED: begin
          key = scan(down, {row, col});
          if (key < DIGIT_TOP) shown = SH_ENTRY;
          if (key == OPEN_KEY && entry_full) begin
            match = 1'b1;
            foreach (entry[i]) if (entry[i] != saved[i]) match = 1'b0;
            if (match) begin
              lock_ph = LP_OPEN;
              ph_cnt  = '0;
              foreach (saved[i]) saved[i] = BLANK_CODE;
              shown       = SH_OPEN;
              wrong_tries = '0;
            end else begin
              if (wrong_tries < TRIES_CAP) wrong_tries++;
              shown = SH_LOCK;
              if (wrong_tries >= max_attempts) begin
                lock_ph     = LP_LOCKDOWN;
                ph_cnt      = '0;
                shown       = SH_DOWN;
                wrong_tries = '0;
              end
            end
            blank_entry();
            entry_full = 1'b0;
          end
        end
        default: begin
          shown = SH_DOWN;
          if (ph_cnt >= lockdown_ticks) begin
            lock_ph = LP_LOCKED;
            shown   = SH_LOCK;
          end else begin
            ph_cnt++;
          end
        end
      endcase

      foreach (show[i]) begin
        case (shown)
          SH_IDLE:  show[i] = '0;
          SH_OPEN:  show[i] = SHOW_OPEN[i];
          SH_ENTRY: show[i] = (i < CODE_DIGITS) ? entry[i] : BLANK_CODE;
          SH_LOCK:  show[i] = SHOW_LOCK[i];
          SH_DOWN:  show[i] = SHOW_DOWN[i];
          default:  show[i] = BLANK_CODE;
        endcase
      end
      st.latch_drive = !(lock_ph == LP_OPEN || lock_ph == LP_PRELOCK);
      st.mode        = lock_ph;
      st.digit_zero  = show[0];
      st.digit_one   = show[1];
      st.digit_two   = show[2];
      st.digit_three = show[3];
      st.tries       = wrong_tries;
      due_status.push_back(st);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_err++;
      end
    endfunction

    function void check_status(lock_status_t got);
      lock_status_t want;
      if (due_status.size() == 0) begin
        $error("status transaction with no scan tick pending");
        n_err++;
        return;
      end
      want = due_status.pop_front();
      cmp_field("latch_drive", 8'(want.latch_drive), 8'(got.latch_drive));
      cmp_field("mode", 8'(want.mode), 8'(got.mode));
      cmp_field("digit_zero", 8'(want.digit_zero), 8'(got.digit_zero));
      cmp_field("digit_one", 8'(want.digit_one), 8'(got.digit_one));
      cmp_field("digit_two", 8'(want.digit_two), 8'(got.digit_two));
      cmp_field("digit_three", 8'(want.digit_three), 8'(got.digit_three));
      cmp_field("tries", 8'(want.tries), 8'(got.tries));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  kcl_in_if  tick_if ();
  kcl_out_if status_if ();

  lock_mirror  mirror;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned send_burst;
  int unsigned recv_burst;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned n_ticks;
  bit          hold_req;

  keypad_combination_lock i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_if),
    .out_o      (status_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Status sink: random stalls, bursts of steady ready, and one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      status_if.ready <= 1'b0;
      hold_left--;
    end else if (recv_burst != 0) begin
      status_if.ready <= 1'b1;
      recv_burst--;
    end else begin
      if ($urandom_range(99) < 2) recv_burst = 40;
      status_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && status_if.valid && status_if.ready)
      mirror.check_status({status_if.latch_drive, status_if.mode, status_if.digit_zero,
                           status_if.digit_one, status_if.digit_two, status_if.digit_three,
                           status_if.tries});
  end

  always @(posedge clk) begin
    if (!rst_n || (tick_if.valid && tick_if.ready) || (status_if.valid && status_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [3:0] pos_of(input disp_t key);
    for (int p = 0; p < 16; p++) if (KEYPAD_MAP[p] == key) return 4'(p);
    return '0;
  endfunction

  function automatic logic [3:0] digit_pos();
    return pos_of(disp_t'($urandom_range(9)));
  endfunction

  task automatic set_mode(input int unsigned m);
    send_idle_pct = (m == 0) ? 17 : (m == 1) ? 87 : 0;
    recv_idle_pct = (m == 0) ? 87 : (m == 1) ? 17 : 0;
  endtask

  task automatic send_tick(input bit down, input logic [1:0] row, input logic [1:0] col);
    @(negedge clk);
    if (send_burst != 0) send_burst--;
    else if ($urandom_range(99) < 2) send_burst = 40;
    while (send_burst == 0 && $urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(negedge clk);
    end
    tick_if.valid    <= 1'b1;
    tick_if.key_down <= down;
    tick_if.key_row  <= row;
    tick_if.key_col  <= col;
    do @(posedge clk); while (!tick_if.ready);
    mirror.take_tick(down, row, col);
    n_ticks++;
  endtask

  task automatic send_noise();
    send_tick(1'($urandom_range(1)), 2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  task automatic send_up();
    send_tick(1'b0, 2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  // One keystroke: hold until the key is taken, then release until debounce is idle again.
  task automatic stroke(input logic [3:0] pos, input bit rough);
    int unsigned guard;
    guard = 0;
    while (mirror.deb_ph != DB_IDLE && guard++ < STROKE_GUARD) send_up();
    guard = 0;
    while (mirror.deb_ph != DB_RELEASE && guard++ < STROKE_GUARD) begin
      if (rough && $urandom_range(3) == 0) send_noise();
      else send_tick(1'b1, pos[3:2], pos[1:0]);
    end
    guard = 0;
    while (mirror.deb_ph != DB_IDLE && guard++ < STROKE_GUARD) begin
      if (rough && $urandom_range(3) == 0) send_noise();
      else send_up();
    end
  endtask

  task automatic wait_phase(input lock_phase_e ph, input bit noisy);
    int unsigned guard;
    guard = 0;
    while (mirror.lock_ph == ph && guard++ < STROKE_GUARD) begin
      if (noisy) send_noise();
      else send_up();
    end
  endtask

  // Pick the next keystroke sequence from the lock phase: mostly well-formed use, some noise.
  task automatic lock_step();
    int unsigned r;
    int unsigned slot;
    disp_t       want;
    r = $urandom_range(99);
    case (mirror.lock_ph)
      LP_IDLE: begin
        if (r < 65) stroke(digit_pos(), 1'b0);
        else if (r < 85) stroke(pos_of(OPEN_KEY), 1'b0);
        else stroke(4'($urandom_range(15)), 1'b1);
      end
      LP_CHOOSE: begin
        if (mirror.entry_full && r < 45) stroke(pos_of(CONFIRM_KEY), 1'b0);
        else if (r < 88) stroke(digit_pos(), 1'b0);
        else stroke(4'($urandom_range(15)), 1'b1);
      end
      LP_PRELOCK: begin
        if (r < 80) wait_phase(LP_PRELOCK, 1'b0);
        else stroke(digit_pos(), 1'b0);
      end
      LP_LOCKED: begin
        if (r < 70) begin
          // Type the saved code, a near miss in one slot, or random digits; then submit.
          slot = $urandom_range(CODE_DIGITS - 1);
          repeat (CODE_DIGITS) begin
            want = mirror.saved[mirror.entry_ptr];
            if (want >= DIGIT_TOP || r >= 55) want = disp_t'($urandom_range(9));
            else if (r >= 40 && mirror.entry_ptr == slot)
              want = disp_t'((32'(want) + 1 + $urandom_range(8)) % 10);
            stroke(pos_of(want), 1'b0);
          end
          stroke(pos_of(OPEN_KEY), 1'b0);
        end else if (r < 88) begin
          stroke(pos_of(OPEN_KEY), 1'b0);
        end else begin
          stroke(4'($urandom_range(15)), 1'b1);
        end
      end
      default: wait_phase(mirror.lock_ph, 1'b1);
    endcase
  endtask

  // Stop offering ticks and wait for every status still owed.
  task automatic drain();
    @(negedge clk);
    tick_if.valid <= 1'b0;
    while (mirror.due_status.size() != 0) @(negedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    mirror.write_reg(idx, data);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] opn,
                            input logic [CFG_W-1:0] pre, input logic [CFG_W-1:0] dwn,
                            input logic [TRY_W-1:0] att);
    write_one(CFG_DEBOUNCE, deb);
    write_one(CFG_OPEN, opn);
    write_one(CFG_PRELOCK, pre);
    write_one(CFG_LOCKDOWN, dwn);
    write_one(CFG_ATTEMPTS, {(CFG_W - TRY_W)'($urandom), att});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned      start_ticks;
    int unsigned      phase_end;
    logic [CFG_W-1:0] deb;

    mirror            = new();
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    tick_if.valid     = 1'b0;
    tick_if.key_down  = 1'b0;
    tick_if.key_row   = '0;
    tick_if.key_col   = '0;
    status_if.ready   = 1'b0;
    hold_req          = 1'b0;
    hold_left         = 0;
    send_burst        = 0;
    recv_burst        = 0;
    quiet_cycles      = 0;
    n_ticks           = 0;
    set_mode(0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Run briefly on the reset timing.
    repeat (1) lock_step();

    // Zero timers and attempts; spare indexes must be ignored.
    drain();
    for (int k = CFG_ATTEMPTS + 1; k < (1 << CFG_IDX_W); k++)
      write_one(CFG_IDX_W'(k), CFG_W'($urandom));
    write_regs('0, '0, '0, '0, '0);
    for (int p = 0; p < 16; p++) send_tick(1'b1, 2'(p >> 2), 2'(p));
    send_tick(1'b0, 2'b11, 2'b11);
    send_tick(1'b0, 2'b00, 2'b00);
    send_tick(1'b1, 2'b11, 2'b11);
    send_tick(1'b0, 2'b01, 2'b10);
    send_tick(1'b1, 2'b00, 2'b00);
    send_tick(1'b0, 2'b10, 2'b01);
    repeat (30) lock_step();

    // Random phases: sink slow, then source slow, then full rate.
    start_ticks = n_ticks;
    while (n_ticks - start_ticks < RANDOM_ITEMS) begin
      set_mode(3 * (n_ticks - start_ticks) / RANDOM_ITEMS);
      drain();
      deb = ($urandom_range(3) == 0) ? '0 : CFG_W'($urandom_range(3, 1));
      write_regs(deb, CFG_W'($urandom_range(12)), CFG_W'($urandom_range(16)),
                 CFG_W'($urandom_range(16)), TRY_W'($urandom_range(7)));
      if (n_ticks == start_ticks + 0 && hold_req == 1'b0 && hold_left == 0) begin
        send_noise();
        hold_req = 1'b1;
      end
      phase_end = n_ticks + PHASE_ITEMS;
      while (n_ticks < phase_end) lock_step();
    end

    drain();
    repeat (4) @(posedge clk);
    if (mirror.due_status.size() != 0) begin
      $error("%0d status transactions never arrived", mirror.due_status.size());
      mirror.n_err++;
    end
    if (mirror.n_err == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/kcl_pkg.sv
rtl/kcl_if.sv
rtl/keypad_combination_lock.sv
verif/tb_top.sv
